/* hdl/tjeh_pkg.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram package
// Shared types, codes, bin edges and binning functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tjeh_pkg;

	localparam int PT_BINS           = 9;
	localparam int ETA_OVF_BIN       = 3;
	localparam int DEF_COUNT_WIDTH   = 32;
	localparam int PT_CELLS          = PT_BINS + 1;
	localparam int ETA_CELLS         = ETA_OVF_BIN + 1;
	localparam int CLASS_CELLS       = PT_CELLS * ETA_CELLS;
	localparam int DEPTH             = 2 * CLASS_CELLS;
	localparam int IDX_W             = $clog2(DEPTH);
	localparam int NLEVELS           = 4;
	localparam int RESULT_W          = 32;
	localparam int THR_W             = 16;
	localparam int PT_W              = 16;
	localparam int ETA_W             = 11;
	localparam int Q_DEPTH           = 2;
	localparam int Q_PTR_W           = $clog2(Q_DEPTH);
	localparam int Q_CNT_W           = $clog2(Q_DEPTH + 1);
	localparam int ADDR_W            = 4;
	localparam int DATA_W            = 32;

	localparam logic OP_FILL         = 1'b0;
	localparam logic OP_READ         = 1'b1;
	localparam logic CLS_HEAVY       = 1'b0;
	localparam logic CLS_LIGHT       = 1'b1;
	localparam logic [2:0] FLAV_LIGHT = 3'd0;
	localparam logic [2:0] FLAV_CHARM = 3'd4;
	localparam logic [2:0] FLAV_BOTTOM = 3'd5;

	localparam logic [1:0] LVL_ALL    = 2'd0;
	localparam logic [1:0] LVL_LOOSE  = 2'd1;
	localparam logic [1:0] LVL_MEDIUM = 2'd2;
	localparam logic [1:0] LVL_TIGHT  = 2'd3;

	localparam logic [1:0] REG_LOOSE  = 2'd0;
	localparam logic [1:0] REG_MEDIUM = 2'd1;
	localparam logic [1:0] REG_TIGHT  = 2'd2;

	localparam logic [THR_W-1:0] LOOSE_RESET  = 16'd1612;
	localparam logic [THR_W-1:0] MEDIUM_RESET = 16'd8336;
	localparam logic [THR_W-1:0] TIGHT_RESET  = 16'd30461;

	// pt edges in 1/8 GeV, |eta| edges in 0.01
	localparam logic [PT_W-1:0] PT_EDGES [PT_CELLS] = '{
		16'd0, 16'd240, 16'd400, 16'd560, 16'd800,
		16'd1120, 16'd1600, 16'd2400, 16'd4800, 16'd8000
	};
	localparam logic [ETA_W-1:0] ETA_EDGES [ETA_CELLS] = '{
		11'd0, 11'd60, 11'd120, 11'd240
	};

	typedef struct packed {
		logic [THR_W-1:0] loose;
		logic [THR_W-1:0] mid;
		logic [THR_W-1:0] tight;
	} thr_t;

	typedef struct packed {
		logic             rd;
		logic             oor;
		logic [1:0]       lvl;
		logic [2:0]       hit;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	function automatic logic [3:0] pt_bin_of(input logic [PT_W-1:0] v);
		logic [3:0] b;
		b = '0;
		for (int i = 1; i <= PT_BINS; i++) begin
			if (v >= PT_EDGES[i]) begin
				b = 4'(i);
			end
		end
		return b;
	endfunction

	function automatic logic [1:0] eta_bin_of(input logic [ETA_W-1:0] a);
		logic [1:0] b;
		b = '0;
		for (int i = 1; i <= ETA_OVF_BIN; i++) begin
			if (a >= ETA_EDGES[i]) begin
				b = 2'(i);
			end
		end
		return b;
	endfunction

endpackage

`default_nettype wire

/* hdl/tjeh_if.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tjeh_in_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [15:0]       jet_pt;
	logic signed [10:0] jet_eta;
	logic [2:0]        flavour;
	logic [15:0]       tag_score;
	logic              sel_class;
	logic [1:0]        sel_level;
	logic [3:0]        sel_pt_bin;
	logic [1:0]        sel_eta_bin;

	modport source (
		output valid, opcode, jet_pt, jet_eta, flavour, tag_score,
		       sel_class, sel_level, sel_pt_bin, sel_eta_bin,
		input  ready
	);
	modport sink (
		input  valid, opcode, jet_pt, jet_eta, flavour, tag_score,
		       sel_class, sel_level, sel_pt_bin, sel_eta_bin,
		output ready
	);
endinterface

interface tjeh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] count;

	modport source (output valid, count, input ready);
	modport sink (input valid, count, output ready);
endinterface

`default_nettype wire

/* hdl/tjeh_ram.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tjeh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/tjeh_front.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram front end
// Accepts request items, bins fills and decodes reads into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tjeh_front (
	tjeh_in_if.sink             req,
	input  wire tjeh_pkg::thr_t thr,
	input  wire logic           q_full,
	output logic                q_push,
	output tjeh_pkg::cmd_t      q_cmd
);

	logic                        cls;
	logic                        keep;
	logic [3:0]                  pb;
	logic [1:0]                  eb;
	logic [tjeh_pkg::ETA_W-1:0]  aeta;

	assign req.ready = !q_full;

	always_comb begin
		aeta = req.jet_eta[tjeh_pkg::ETA_W-1] ? tjeh_pkg::ETA_W'(~req.jet_eta + 1'b1)
		                                      : req.jet_eta;
		keep = 1'b1;
		cls  = tjeh_pkg::CLS_HEAVY;
		case (req.flavour) inside
			tjeh_pkg::FLAV_CHARM, tjeh_pkg::FLAV_BOTTOM: cls = tjeh_pkg::CLS_HEAVY;
			tjeh_pkg::FLAV_LIGHT: cls = tjeh_pkg::CLS_LIGHT;
			default: keep = 1'b0;
		endcase

		q_cmd = '0;
		if (req.opcode == tjeh_pkg::OP_READ) begin
			keep      = 1'b1;
			cls       = req.sel_class;
			pb        = req.sel_pt_bin;
			eb        = req.sel_eta_bin;
			q_cmd.rd  = 1'b1;
			q_cmd.lvl = req.sel_level;
			q_cmd.oor = (int'(req.sel_pt_bin) > tjeh_pkg::PT_BINS) ||
			            (int'(req.sel_eta_bin) > tjeh_pkg::ETA_OVF_BIN);
		end else begin
			pb        = tjeh_pkg::pt_bin_of(req.jet_pt);
			eb        = tjeh_pkg::eta_bin_of(aeta);
			q_cmd.hit = {req.tag_score > thr.tight, req.tag_score > thr.mid,
			             req.tag_score > thr.loose};
		end
		q_cmd.idx = tjeh_pkg::IDX_W'(cls) * tjeh_pkg::IDX_W'(tjeh_pkg::CLASS_CELLS)
		          + tjeh_pkg::IDX_W'(pb) * tjeh_pkg::IDX_W'(tjeh_pkg::ETA_CELLS)
		          + tjeh_pkg::IDX_W'(eb);
	end

	assign q_push = req.valid && req.ready && keep;

endmodule

`default_nettype wire

/* hdl/tjeh_queue.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram command queue
// Short FIFO of binned commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tjeh_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tjeh_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output logic                full,
	output logic                head_valid,
	output tjeh_pkg::cmd_t      head
);

	tjeh_pkg::cmd_t                mem_q [tjeh_pkg::Q_DEPTH];
	logic [tjeh_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [tjeh_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [tjeh_pkg::Q_CNT_W-1:0]  cnt_q;

	assign full       = cnt_q == tjeh_pkg::Q_CNT_W'(tjeh_pkg::Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/tjeh_back.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram back end
// Read-modify-write of the counter RAM and result register for reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tjeh_back #(
	parameter int COUNT_WIDTH = tjeh_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire tjeh_pkg::cmd_t q_head,
	output logic                q_pop,
	tjeh_out_if.source          rsp
);

	localparam int WORD_W = tjeh_pkg::NLEVELS * COUNT_WIDTH;
	localparam int EXT_W  = (COUNT_WIDTH > tjeh_pkg::RESULT_W) ? COUNT_WIDTH
	                                                           : tjeh_pkg::RESULT_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} state_t;

	state_t                         state_q;
	tjeh_pkg::cmd_t                 cmd_s1;
	logic [tjeh_pkg::DEPTH-1:0]     valid_q;
	logic                           out_valid_q;
	logic [tjeh_pkg::RESULT_W-1:0]  out_count_q;

	logic [WORD_W-1:0]              rdata;
	logic [WORD_W-1:0]              word;
	logic [WORD_W-1:0]              wdata;
	logic                           we;
	logic [tjeh_pkg::NLEVELS-1:0]   inc;
	logic [COUNT_WIDTH-1:0]         cnt [tjeh_pkg::NLEVELS];
	logic [COUNT_WIDTH-1:0]         sel;
	logic [EXT_W-1:0]               ext;
	logic [tjeh_pkg::RESULT_W-1:0]  result;

	assign q_pop = (state_q == ST_IDLE) && q_valid && (!q_head.rd || !out_valid_q);
	assign we    = (state_q == ST_UPD) && !cmd_s1.rd;

	tjeh_ram #(
		.WIDTH (WORD_W),
		.DEPTH (tjeh_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cmd_s1.idx),
		.wdata (wdata),
		.re    (q_pop),
		.raddr (q_head.idx),
		.rdata (rdata)
	);

	always_comb begin
		word = valid_q[cmd_s1.idx] ? rdata : '0;
		inc  = {cmd_s1.hit, 1'b1};
		for (int k = 0; k < tjeh_pkg::NLEVELS; k++) begin
			cnt[k] = word[k*COUNT_WIDTH +: COUNT_WIDTH];
			wdata[k*COUNT_WIDTH +: COUNT_WIDTH] = (inc[k] && (cnt[k] != '1)) ?
			                                      cnt[k] + 1'b1 : cnt[k];
		end
		sel = cmd_s1.oor ? '0 : cnt[cmd_s1.lvl];
		ext = EXT_W'(sel);
		result = (|(ext >> tjeh_pkg::RESULT_W)) ? '1 : ext[tjeh_pkg::RESULT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_head;
		end
		if ((state_q == ST_UPD) && cmd_s1.rd) begin
			out_count_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (we) begin
				valid_q[cmd_s1.idx] <= 1'b1;
			end
			if ((state_q == ST_UPD) && cmd_s1.rd) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.count = out_count_q;

endmodule

`default_nettype wire

/* hdl/tagged_jet_efficiency_histogram_top.sv */
// A read result goes through the command queue, RAM read and result register.
// The back end takes a new item only after the counter RAM read-modify-write
// loop (registered read, then write back) ends; a 2-entry queue absorbs bursts.
// Fills and ignored flavours give no result; a read waits for a free result register.
// Reset (asynchronous, active low): thresholds take their defaults, and all
// counters read as zero at once through per-entry valid bits.
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram top level
// Threshold registers, front end, command queue and counter back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_jet_efficiency_histogram_top #(
	parameter int COUNT_WIDTH = tjeh_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	tjeh_in_if.sink                          req,
	tjeh_out_if.source                       rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tjeh_pkg::ADDR_W-1:0] paddr,
	input  wire logic [tjeh_pkg::DATA_W-1:0] pwdata,
	output logic      [tjeh_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);

	tjeh_pkg::thr_t thr_q;
	tjeh_pkg::cmd_t push_cmd;
	tjeh_pkg::cmd_t head;
	logic           push;
	logic           pop;
	logic           full;
	logic           head_valid;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.loose <= tjeh_pkg::LOOSE_RESET;
			thr_q.mid   <= tjeh_pkg::MEDIUM_RESET;
			thr_q.tight <= tjeh_pkg::TIGHT_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				tjeh_pkg::REG_LOOSE:  thr_q.loose <= pwdata[tjeh_pkg::THR_W-1:0];
				tjeh_pkg::REG_MEDIUM: thr_q.mid   <= pwdata[tjeh_pkg::THR_W-1:0];
				tjeh_pkg::REG_TIGHT:  thr_q.tight <= pwdata[tjeh_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tjeh_pkg::REG_LOOSE:  prdata = tjeh_pkg::DATA_W'(thr_q.loose);
			tjeh_pkg::REG_MEDIUM: prdata = tjeh_pkg::DATA_W'(thr_q.mid);
			tjeh_pkg::REG_TIGHT:  prdata = tjeh_pkg::DATA_W'(thr_q.tight);
			default:              prdata = '0;
		endcase
	end

	tjeh_front u_front (
		.req    (req),
		.thr    (thr_q),
		.q_full (full),
		.q_push (push),
		.q_cmd  (push_cmd)
	);

	tjeh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	tjeh_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (head_valid),
		.q_head  (head),
		.q_pop   (pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

/* hdl/tjeh_checker.sv */
// ----------------------------------------------------------------------------
// Tagged jet efficiency histogram checker
// Port-level assertions on results and the register port, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tjeh_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [31:0]                 out_count,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [tjeh_pkg::ADDR_W-1:0] paddr,
	input wire logic [tjeh_pkg::DATA_W-1:0] pwdata,
	input wire logic [tjeh_pkg::DATA_W-1:0] prdata,
	input wire logic                        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_count))
		else $error("result dropped or changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:16] == 16'd0)
		else $error("threshold readback wider than 16 bits");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == tjeh_pkg::REG_LOOSE
		|=> !(psel && !pwrite && paddr[3:2] == tjeh_pkg::REG_LOOSE) ||
		    prdata[15:0] == $past(pwdata[15:0]))
		else $error("loose threshold readback mismatch");

endmodule

bind tagged_jet_efficiency_histogram_top tjeh_checker u_tjeh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_count (rsp.count),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);

`default_nettype wire
